[rtl/core/fbm_pkg.sv]
// Shared types, constants and the octave weight table for the fBm noise pixel block.
// No dependencies; every other file of the block imports this package.
package fbm_pkg;

   localparam int COORD_W         = 24;
   localparam int SUM_W           = 22;
   localparam int HASH_W          = 32;
   localparam int WEIGHT_W        = 19;
   localparam int NOISE_W         = 31;
   localparam int DEF_OCTAVES     = 16;
   localparam int DEF_FRAC_BITS   = 8;
   localparam int OCT_STAGES      = 5;

   localparam logic [HASH_W-1:0]   HASH_ROW_MUL = 32'd57;
   localparam logic [HASH_W-1:0]   HASH_MUL_A   = 32'd15731;
   localparam logic [HASH_W-1:0]   HASH_ADD_A   = 32'd789221;
   localparam logic [HASH_W-1:0]   HASH_ADD_B   = 32'd1376312589;
   localparam logic [NOISE_W-1:0]  NOISE_MID    = 31'h4000_0000;
   localparam logic [15:0]         SCALE_Q16    = 16'd19661;
   localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};

   // Coordinates and running sum that travel with each beat.
   typedef struct packed {
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic [SUM_W-1:0]   noise_sum;
   } fbm_beat_type;

   // Octave weight 0.3^(-0.1*i) in Q3.16, rounded, saturated from octave 18 on.
   function automatic logic [WEIGHT_W-1:0] octave_weight(input logic [4:0] idx);
      logic [WEIGHT_W-1:0] w;
      unique case (idx)
         5'd0:    w = 19'd65536;
         5'd1:    w = 19'd73921;
         5'd2:    w = 19'd83379;
         5'd3:    w = 19'd94047;
         5'd4:    w = 19'd106079;
         5'd5:    w = 19'd119652;
         5'd6:    w = 19'd134961;
         5'd7:    w = 19'd152228;
         5'd8:    w = 19'd171705;
         5'd9:    w = 19'd193674;
         5'd10:   w = 19'd218453;
         5'd11:   w = 19'd246403;
         5'd12:   w = 19'd277929;
         5'd13:   w = 19'd313489;
         5'd14:   w = 19'd353598;
         5'd15:   w = 19'd398839;
         5'd16:   w = 19'd449869;
         5'd17:   w = 19'd507427;
         default: w = 19'd524287;
      endcase
      return w;
   endfunction

endpackage

[rtl/core/fbm_req_if.sv]
// Request channel of the fBm noise pixel block: one coordinate pair per beat.
// Depends on fbm_pkg for the field widths.
interface fbm_req_if;
   import fbm_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] x_coord;
   logic [COORD_W-1:0] y_coord;
   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

[rtl/core/fbm_rsp_if.sv]
// Response channel of the fBm noise pixel block: one noise sum per beat.
// Depends on fbm_pkg for the field width.
interface fbm_rsp_if;
   import fbm_pkg::*;
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] noise_sum;
   modport source (output valid, output noise_sum, input ready);
   modport sink   (input valid, input noise_sum, output ready);
endinterface

[rtl/core/fbm_octave.sv]
// One octave of the fBm sum as a five-stage pipeline: hash, weight, accumulate, rescale.
// Depends on fbm_pkg.
module fbm_octave
   import fbm_pkg::*;
#(
   parameter int OCT_INDEX       = 0,
   parameter int COORD_FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  fbm_beat_type in_beat,
   output logic         out_valid,
   output fbm_beat_type out_beat
);

   localparam logic [WEIGHT_W-1:0] WEIGHT = octave_weight(5'(OCT_INDEX));

   logic [OCT_STAGES-1:0] valid_ff, valid_in;
   fbm_beat_type          beat_ff [OCT_STAGES];
   fbm_beat_type          beat_in [OCT_STAGES];
   logic [HASH_W-1:0]     n_ff [OCT_STAGES-2];
   logic [HASH_W-1:0]     sq_ff, t_ff;
   logic [NOISE_W-1:0]    h_ff;

   logic [HASH_W-1:0]     ix, iy, n_sum, n_in, sq_in, t_in;
   logic [NOISE_W-1:0]    h_in, noise;
   logic [NOISE_W+WEIGHT_W-1:0] prod_full;
   logic [WEIGHT_W-1:0]   prod;
   logic [SUM_W:0]        acc;
   logic [2*COORD_W-1:0]  xs_full, ys_full;

   always_comb begin
      ix       = HASH_W'(in_beat.x_coord >> COORD_FRAC_BITS);
      iy       = HASH_W'(in_beat.y_coord >> COORD_FRAC_BITS);
      n_sum    = ix + iy * HASH_ROW_MUL;
      n_in     = {n_sum[HASH_W-2:0], 1'b0} ^ n_sum;
      sq_in    = n_ff[0] * n_ff[0];
      t_in     = sq_ff * HASH_MUL_A + HASH_ADD_A;
      h_in     = NOISE_W'(n_ff[2] * t_ff + HASH_ADD_B);
      noise    = (h_ff <= NOISE_MID) ? (NOISE_MID - h_ff) : (h_ff - NOISE_MID);
      prod_full = (NOISE_W+WEIGHT_W)'(noise) * (NOISE_W+WEIGHT_W)'(WEIGHT);
      prod     = prod_full[30 +: WEIGHT_W];
      acc      = (SUM_W+1)'(beat_ff[3].noise_sum) + (SUM_W+1)'(prod);
      xs_full  = (2*COORD_W)'(beat_ff[3].x_coord) * (2*COORD_W)'(SCALE_Q16);
      ys_full  = (2*COORD_W)'(beat_ff[3].y_coord) * (2*COORD_W)'(SCALE_Q16);

      valid_in = {valid_ff[OCT_STAGES-2:0], in_valid};
      beat_in[0] = in_beat;
      for (int s = 1; s < OCT_STAGES; s++) begin
         beat_in[s] = beat_ff[s-1];
      end
      // The last stage adds this octave and scales the coordinates for the next one.
      beat_in[4].noise_sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      beat_in[4].x_coord   = xs_full[16 +: COORD_W];
      beat_in[4].y_coord   = ys_full[16 +: COORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < OCT_STAGES; s++) begin
            beat_ff[s] <= beat_in[s];
         end
         n_ff[0] <= n_in;
         n_ff[1] <= n_ff[0];
         n_ff[2] <= n_ff[1];
         sq_ff   <= sq_in;
         t_ff    <= t_in;
         h_ff    <= h_in;
      end
   end

   assign out_valid = valid_ff[OCT_STAGES-1];
   assign out_beat  = beat_ff[OCT_STAGES-1];

endmodule

[rtl/core/fbm_value_noise_pixel.sv]
// Fractional Brownian motion pixel: takes a Q16.8 coordinate pair per beat and returns the
// Q6.16 sum of OCTAVES octaves of hashed value noise. A new coordinate pair is accepted on
// every clock while the pipeline is not stalled; each octave is a five-stage pipeline (hash mix,
// hash square, hash polynomial, hash product, weighting and accumulate), and the octaves
// are chained in order. An output register holds the result; the whole pipeline
// stalls only while that register is full and the response is not taken. Depends on
// fbm_pkg and the channel interfaces.
module fbm_value_noise_pixel
   import fbm_pkg::*;
#(
   parameter int OCTAVES         = DEF_OCTAVES,
   parameter int COORD_FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic   clock,
   input  logic   reset,
   fbm_req_if.sink   req_chan,
   fbm_rsp_if.source rsp_chan
);

   logic               advance;
   logic               chain_valid [OCTAVES+1];
   fbm_beat_type       chain_beat  [OCTAVES+1];
   logic               rsp_valid_ff;
   logic [SUM_W-1:0]   rsp_sum_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign chain_valid[0] = req_chan.valid;
   assign chain_beat[0]  = '{x_coord: req_chan.x_coord, y_coord: req_chan.y_coord,
                             noise_sum: '0};

   for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
      fbm_octave #(
         .OCT_INDEX       (g),
         .COORD_FRAC_BITS (COORD_FRAC_BITS)
      ) u_octave (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[g]),
         .in_beat   (chain_beat[g]),
         .out_valid (chain_valid[g+1]),
         .out_beat  (chain_beat[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[OCTAVES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sum_ff <= chain_beat[OCTAVES].noise_sum;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.noise_sum = rsp_sum_ff;

endmodule

[rtl/core/fbm_checker.sv]
// Port-level checks for the fBm noise pixel block, bound to its top level.
// Depends on fbm_pkg.
module fbm_checker
   import fbm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SUM_W-1:0] rsp_noise_sum
);

   // No response may be shown in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An empty output register always lets the pipeline take a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   // A stalled response stalls the request side too.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken during response stall");

   // A stalled response beat holds its data.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_noise_sum)))
      else $error("stalled response changed");

endmodule

bind fbm_value_noise_pixel fbm_checker u_fbm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_noise_sum (rsp_chan.noise_sum)
);
